[design/twrms_pkg.sv]
package twrms_pkg;

  localparam int NUM_AXES   = 3;
  localparam int MAX_STAGES = 4;
  localparam int SLOTS      = 5;
  localparam int TAPS       = 4;
  localparam int DATA_BITS  = 32;
  localparam int SAT_IN_W   = 40;

  localparam int COEF_DEPTH = MAX_STAGES * SLOTS;
  localparam int COEF_AW    = $clog2(COEF_DEPTH);
  localparam int SEC_W      = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int DL_DEPTH   = NUM_AXES * (1 << SEC_W) * TAPS;
  localparam int DL_AW      = $clog2(DL_DEPTH);

  localparam logic [1:0] CFG_EPOCH_LENGTH    = 2'd0;
  localparam logic [1:0] CFG_ACTIVE_SECTIONS = 2'd1;
  localparam logic [1:0] CFG_LSB_SCALE       = 2'd2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEFF  = 1'b1;

  localparam logic [15:0] EPOCH_LENGTH_RST    = 16'd3200;
  localparam logic [2:0]  ACTIVE_SECTIONS_RST = 3'd4;
  localparam logic [23:0] LSB_SCALE_RST       = 24'd641660;

  typedef logic signed [DATA_BITS-1:0] data_t;
  typedef logic signed [31:0]          coef_t;
  typedef logic signed [15:0]          accel_t;
  typedef logic [63:0]                 sum_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic data_t sat_data(input logic signed [SAT_IN_W-1:0] v);
    if (v[SAT_IN_W-1:DATA_BITS-1] == {(SAT_IN_W-DATA_BITS+1){v[SAT_IN_W-1]}})
      return v[DATA_BITS-1:0];
    else if (v[SAT_IN_W-1])
      return {1'b1, {(DATA_BITS-1){1'b0}}};
    else
      return {1'b0, {(DATA_BITS-1){1'b1}}};
  endfunction

  function automatic sum_t add_sat(input sum_t a, input sum_t b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

endpackage

[design/twrms_div.sv]
module twrms_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  twrms_pkg::sum_t        dividend,
  input  logic [15:0]            divisor,
  output twrms_pkg::sum_t        quot,
  output twrms_pkg::unit_stat_t  stat
);
  import twrms_pkg::*;

  localparam int DIV_STEPS = 64;

  sum_t        q_r;
  logic [16:0] rem_r;
  logic [15:0] d_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [16:0] rem_sh, rem_nx;
  logic        ge;

  always_comb begin
    rem_sh = {rem_r[15:0], q_r[63]};
    ge     = rem_sh >= {1'b0, d_r};
    rem_nx = ge ? (rem_sh - {1'b0, d_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[62:0], ge};
      rem_r <= rem_nx;
    end
  end

  assign quot      = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[design/twrms_isqrt.sv]
module twrms_isqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  twrms_pkg::sum_t        radicand,
  output logic [31:0]            root,
  output twrms_pkg::unit_stat_t  stat
);
  import twrms_pkg::*;

  localparam int SQ_STEPS = 32;

  sum_t        v_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [33:0] rem_t, trial;
  logic        ge;

  always_comb begin
    rem_t = {rem_r[31:0], v_r[63:62]};
    trial = {root_r, 2'b01};
    ge    = rem_t >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(SQ_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      v_r    <= {v_r[61:0], 2'b00};
      rem_r  <= ge ? (rem_t - trial) : rem_t;
      root_r <= {root_r[30:0], ge};
    end
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[design/tri_axis_weighted_rms_epoch_unit.sv]
// channel | direction | payload                                        | handshake
// in      | input     | operation, accel_x/y/z, coeff_index/value      | in_valid / in_stall
// out     | output    | rms_x/y/z, vector_sum, samples_in_epoch, epoch | out_valid / out_stall
// cfg     | input     | cfg_index, cfg_data                            | cfg_valid / cfg_ready
//
// A sample word walks every tap of the active sections (clamped to 4) through the
// delay-line RAM with one shared 33x33 multiplier.
// Epoch close runs a 64-step divider and a 32-step square root per axis, then a vector root.
// Sync active-low reset clears coefficients, delay-line valid bits, sums and counters.
// A finished result waits in the output register; a new one waits while out_stall is high.
module tri_axis_weighted_rms_epoch_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  twrms_pkg::accel_t  in_accel_x,
  input  twrms_pkg::accel_t  in_accel_y,
  input  twrms_pkg::accel_t  in_accel_z,
  input  logic [4:0]         in_coeff_index,
  input  twrms_pkg::coef_t   in_coeff_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_rms_x,
  output logic [31:0]        out_rms_y,
  output logic [31:0]        out_rms_z,
  output logic [31:0]        out_vector_sum,
  output logic [15:0]        out_samples_in_epoch,
  output logic [31:0]        out_epoch_number,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import twrms_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_SCALE = 17'h00002,
    S_XLD   = 17'h00004,
    S_RD    = 17'h00008,
    S_MAC   = 17'h00010,
    S_WB    = 17'h00020,
    S_SQ    = 17'h00040,
    S_ACC   = 17'h00080,
    S_DIV   = 17'h00100,
    S_DIVW  = 17'h00200,
    S_ISQ   = 17'h00400,
    S_ISQW  = 17'h00800,
    S_RSQ   = 17'h01000,
    S_RACC  = 17'h02000,
    S_VSQ   = 17'h04000,
    S_VSQW  = 17'h08000,
    S_LOAD  = 17'h10000
  } state_t;

  localparam logic [2:0] RD_LAST   = 3'(TAPS);
  localparam logic [2:0] MAC_LAST  = 3'(SLOTS);
  localparam logic [2:0] WB_LAST   = 3'(TAPS - 1);
  localparam logic [1:0] LAST_AXIS = 2'(NUM_AXES - 1);

  state_t state_r, state_nxt;

  logic [15:0] epoch_len_r;
  logic [2:0]  act_sec_r;
  logic [23:0] lsb_scale_r;

  coef_t  coef_r [COEF_DEPTH];
  accel_t raw_r  [NUM_AXES];

  logic [1:0]       axis_r;
  logic [SEC_W-1:0] sec_r;
  logic [2:0]       k_r;

  data_t x_r, y_r;
  data_t d_r [TAPS];
  logic signed [SAT_IN_W-1:0] acc_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;
  logic signed [35:0] term;

  sum_t        sums_r [NUM_AXES];
  logic [15:0] cnt_r, cnt_inc;
  logic [31:0] epoch_r;
  logic [31:0] rms_r [NUM_AXES];
  sum_t        vsum_r;
  logic [31:0] vres_r;

  data_t             dl_mem [DL_DEPTH];
  logic [DL_DEPTH-1:0] dl_vld_r;
  logic [DL_AW-1:0]  dl_addr;
  logic              wr_en;
  data_t             wr_data, rd_q_r, rd_data;
  logic              rd_v_r;

  logic [2:0]         nsec;
  logic               more_sec;
  logic [COEF_AW-1:0] cidx;
  coef_t              coef_sel;
  data_t              mac_data;

  logic       div_start, sq_start;
  sum_t       quot, sq_in;
  logic [31:0] sq_root;
  unit_stat_t div_st, sq_st;

  logic in_acc, load_fire, out_valid_r;
  logic [31:0] o_rms_x_r, o_rms_y_r, o_rms_z_r, o_vsum_r, o_epoch_r;
  logic [15:0] o_cnt_r;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign load_fire = (state_r == S_LOAD) && (!out_valid_r || !out_stall);

  assign nsec     = (act_sec_r > 3'(MAX_STAGES)) ? 3'(MAX_STAGES) : act_sec_r;
  assign more_sec = (3'(sec_r) + 3'd1) < nsec;
  assign cnt_inc  = cnt_r + 16'd1;
  assign cidx     = COEF_AW'(int'(sec_r) * SLOTS + int'(k_r));
  assign term     = prod_r[63:28];
  assign dl_addr  = DL_AW'({axis_r, sec_r, k_r[1:0]});
  assign wr_en    = (state_r == S_WB);
  assign rd_data  = rd_v_r ? rd_q_r : '0;

  always_comb begin
    coef_sel = '0;
    for (int i = 0; i < COEF_DEPTH; i++) begin
      if (cidx == COEF_AW'(i)) coef_sel = coef_r[i];
    end
  end

  always_comb begin
    case (k_r)
      3'd0:    mac_data = x_r;
      3'd1:    mac_data = d_r[0];
      3'd2:    mac_data = d_r[1];
      3'd3:    mac_data = d_r[2];
      default: mac_data = d_r[3];
    endcase
  end

  always_comb begin
    case (k_r[1:0])
      2'd0:    wr_data = x_r;
      2'd1:    wr_data = d_r[0];
      2'd2:    wr_data = y_r;
      default: wr_data = d_r[2];
    endcase
  end

  always_comb begin
    case (state_r)
      S_SCALE: begin
        mul_a = 33'(raw_r[axis_r]);
        mul_b = {9'd0, lsb_scale_r};
      end
      S_MAC: begin
        mul_a = 33'(mac_data);
        mul_b = 33'(coef_sel);
      end
      S_SQ: begin
        mul_a = 33'(x_r);
        mul_b = 33'(x_r);
      end
      S_RSQ: begin
        mul_a = {1'b0, rms_r[axis_r]};
        mul_b = {1'b0, rms_r[axis_r]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && in_operation == OP_SAMPLE) state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_XLD;
      S_XLD:   state_nxt = (nsec == 3'd0) ? S_SQ : S_RD;
      S_RD:    if (k_r == RD_LAST) state_nxt = S_MAC;
      S_MAC:   if (k_r == MAC_LAST) state_nxt = S_WB;
      S_WB:    if (k_r == WB_LAST) state_nxt = more_sec ? S_RD : S_SQ;
      S_SQ:    state_nxt = S_ACC;
      S_ACC: begin
        if (axis_r != LAST_AXIS) state_nxt = S_SCALE;
        else if (cnt_inc >= epoch_len_r) state_nxt = S_DIV;
        else state_nxt = S_IDLE;
      end
      S_DIV:   state_nxt = S_DIVW;
      S_DIVW:  if (div_st.done) state_nxt = S_ISQ;
      S_ISQ:   state_nxt = S_ISQW;
      S_ISQW:  if (sq_st.done) state_nxt = S_RSQ;
      S_RSQ:   state_nxt = S_RACC;
      S_RACC:  state_nxt = (axis_r == LAST_AXIS) ? S_VSQ : S_DIV;
      S_VSQ:   state_nxt = S_VSQW;
      S_VSQW:  if (sq_st.done) state_nxt = S_LOAD;
      S_LOAD:  if (load_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      epoch_len_r <= EPOCH_LENGTH_RST;
      act_sec_r   <= ACTIVE_SECTIONS_RST;
      lsb_scale_r <= LSB_SCALE_RST;
      for (int i = 0; i < COEF_DEPTH; i++) coef_r[i] <= '0;
      for (int i = 0; i < NUM_AXES; i++) sums_r[i] <= '0;
      axis_r      <= '0;
      sec_r       <= '0;
      k_r         <= '0;
      cnt_r       <= '0;
      epoch_r     <= '0;
      dl_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_EPOCH_LENGTH:    epoch_len_r <= cfg_data[15:0];
          CFG_ACTIVE_SECTIONS: act_sec_r   <= cfg_data[2:0];
          CFG_LSB_SCALE:       lsb_scale_r <= cfg_data;
          default: ;
        endcase
      end

      if (in_acc && in_operation == OP_COEFF && in_coeff_index < 5'(COEF_DEPTH))
        coef_r[COEF_AW'(in_coeff_index)] <= in_coeff_value;

      if (in_acc) axis_r <= '0;

      case (state_r)
        S_XLD: begin
          sec_r <= '0;
          k_r   <= '0;
        end
        S_RD:  k_r <= (k_r == RD_LAST) ? 3'd0 : k_r + 3'd1;
        S_MAC: k_r <= (k_r == MAC_LAST) ? 3'd0 : k_r + 3'd1;
        S_WB: begin
          if (k_r == WB_LAST) begin
            k_r <= '0;
            if (more_sec) sec_r <= sec_r + 1'b1;
          end else begin
            k_r <= k_r + 3'd1;
          end
        end
        S_ACC: begin
          sums_r[axis_r] <= add_sat(sums_r[axis_r], prod_r[63:0]);
          if (axis_r == LAST_AXIS) begin
            axis_r <= '0;
            cnt_r  <= cnt_inc;
          end else begin
            axis_r <= axis_r + 2'd1;
          end
        end
        S_RACC: axis_r <= (axis_r == LAST_AXIS) ? 2'd0 : axis_r + 2'd1;
        default: ;
      endcase

      if (wr_en) dl_vld_r[dl_addr] <= 1'b1;

      if (load_fire) begin
        for (int i = 0; i < NUM_AXES; i++) sums_r[i] <= '0;
        cnt_r       <= '0;
        epoch_r     <= epoch_r + 32'd1;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // delay-line RAM, one read and one write port
  always_ff @(posedge clk) begin
    if (wr_en) dl_mem[dl_addr] <= wr_data;
    rd_q_r <= dl_mem[dl_addr];
    rd_v_r <= dl_vld_r[dl_addr];
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;

    if (in_acc && in_operation == OP_SAMPLE) begin
      raw_r[0] <= in_accel_x;
      raw_r[1] <= in_accel_y;
      raw_r[2] <= in_accel_z;
    end

    case (state_r)
      S_XLD: x_r <= sat_data(prod_r[47:8]);
      S_RD:  if (k_r != 3'd0) d_r[k_r[1:0] - 2'd1] <= rd_data;
      S_MAC: begin
        if (k_r == 3'd0) acc_r <= '0;
        else if (k_r >= 3'd4) acc_r <= acc_r - SAT_IN_W'(term);
        else acc_r <= acc_r + SAT_IN_W'(term);
      end
      S_WB: begin
        if (k_r == 3'd0) y_r <= sat_data(acc_r);
        if (k_r == WB_LAST) x_r <= y_r;
      end
      S_ACC:  vsum_r <= '0;
      S_ISQW: if (sq_st.done) rms_r[axis_r] <= sq_root;
      S_RACC: vsum_r <= add_sat(vsum_r, prod_r[63:0]);
      S_VSQW: if (sq_st.done) vres_r <= sq_root;
      default: ;
    endcase

    if (load_fire) begin
      o_rms_x_r <= rms_r[0];
      o_rms_y_r <= rms_r[1];
      o_rms_z_r <= rms_r[2];
      o_vsum_r  <= vres_r;
      o_cnt_r   <= cnt_r;
      o_epoch_r <= epoch_r;
    end
  end

  assign div_start = (state_r == S_DIV);
  assign sq_start  = (state_r == S_ISQ) || (state_r == S_VSQ);
  assign sq_in     = (state_r == S_VSQ) ? vsum_r : quot;

  twrms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sums_r[axis_r]),
    .divisor  (cnt_r),
    .quot     (quot),
    .stat     (div_st)
  );

  twrms_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_in),
    .root     (sq_root),
    .stat     (sq_st)
  );

  assign out_valid            = out_valid_r;
  assign out_rms_x            = o_rms_x_r;
  assign out_rms_y            = o_rms_y_r;
  assign out_rms_z            = o_rms_z_r;
  assign out_vector_sum       = o_vsum_r;
  assign out_samples_in_epoch = o_cnt_r;
  assign out_epoch_number     = o_epoch_r;

  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_LOAD))
    else $error("result word raised outside load");

  a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r != 16'd0 && !div_st.busy))
    else $error("divider started with zero count or while busy");

  a_sq_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_ISQ) || (state_r == S_VSQ)) |-> !sq_st.busy)
    else $error("square root started while busy");

  a_sec_rng: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (3'(sec_r) < nsec))
    else $error("section index beyond active sections");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD && out_valid_r && out_stall) |=> (state_r == S_LOAD))
    else $error("pending result word overwritten");

endmodule
